[design/b64d_pkg.sv]
package b64d_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [5:0]  SEXT_PLUS  = 6'd62;
  localparam logic [5:0]  SEXT_SLASH = 6'd63;
  localparam logic [7:0]  DIGIT_OFS  = 8'd52;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nb;
    logic            last;
    logic [31:0]     total;
    logic            halted;
  } job_t;

  typedef struct packed {
    logic ok;
    logic [5:0] val;
  } sext_t;

  function automatic sext_t classify(input logic [7:0] c);
    sext_t r;
    logic [7:0] t;
    r = '{ok: 1'b1, val: 6'd0};
    t = 8'd0;
    case (c) inside
      ["A":"Z"]: begin
        t = c - 8'd65;
        r.val = t[5:0];
      end
      ["a":"z"]: begin
        t = c - 8'd97 + 8'd26;
        r.val = t[5:0];
      end
      ["0":"9"]: begin
        t = c - 8'd48 + DIGIT_OFS;
        r.val = t[5:0];
      end
      "+": r.val = SEXT_PLUS;
      "/": r.val = SEXT_SLASH;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[design/b64d_in_if.sv]
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

[design/b64d_out_if.sv]
interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        stream_end;
  logic [31:0] total_count;
  logic        halted_flag;
  logic        run_last;

  modport source (output valid, output out_byte, output byte_valid, output stream_end,
                  output total_count, output halted_flag, output run_last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input stream_end,
                input total_count, input halted_flag, input run_last, output ready);
endinterface

[design/base64_stream_decoder_top.sv]
// Base64 (standard alphabet) stream decoder. One character word is accepted per cycle
// whenever the four-entry job queue between the classifier front end and the output
// sequencer has room; the front end gathers groups of four characters and queues a job
// for each group that yields bytes and for each last-marked character. The back end sends
// one result word per cycle from its output register while the output is ready: up to
// three byte words per group and one closing word with the saturated byte count. The
// first result passes through the queue memory and then the output register after the
// character that causes it.
module base64_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  b64d_in_if.sink     din,
  b64d_out_if.source  dout
);

  b64d_pkg::job_t job, head;
  logic           push, pop, full, empty;

  b64d_front u_front (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .full (full),
    .push (push),
    .job  (job)
  );

  b64d_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  b64d_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .dout  (dout)
  );

endmodule

[design/b64d_front.sv]
module b64d_front (
  input  logic           clk,
  input  logic           rst,
  b64d_in_if.sink        din,
  input  logic           full,
  output logic           push,
  output b64d_pkg::job_t job
);

  logic [1:0]       pos, pos_next;
  logic [2:0][5:0]  sext, sext_next;
  logic             third_ok, third_ok_next;
  logic [1:0]       pb, pb_next;
  logic             halted, halted_next;
  logic [31:0]      count, count_next;
  logic [32:0]      sum;
  logic [1:0]       nb;
  logic             acc;
  b64d_pkg::sext_t  cls;

  assign din.ready = !full;
  assign acc       = din.valid && din.ready;
  assign cls       = b64d_pkg::classify(din.in_char);

  always_comb begin
    pos_next      = pos;
    sext_next     = sext;
    third_ok_next = third_ok;
    pb_next       = pb;
    halted_next   = halted;
    nb            = 2'd0;
    if (acc && !halted) begin
      if (pos != 2'd3) begin
        sext_next[pos] = cls.val;
        if (pos == 2'd2) begin
          third_ok_next = cls.ok;
        end else begin
          pb_next[pos[0]] = !cls.ok;
        end
        pos_next = pos + 2'd1;
      end else begin
        pos_next = 2'd0;
        if (|pb) begin
          halted_next = 1'b1;
        end else begin
          nb = third_ok ? (cls.ok ? 2'd3 : 2'd2) : 2'd1;
        end
        third_ok_next = 1'b0;
        pb_next       = 2'b00;
      end
    end
    sum        = {1'b0, count} + {31'd0, nb};
    count_next = sum[32] ? b64d_pkg::CNT_MAX : sum[31:0];

    job.bytes[0] = {sext[0], sext[1][5:4]};
    job.bytes[1] = {sext[1][3:0], sext[2][5:2]};
    job.bytes[2] = {sext[2][1:0], cls.val};
    job.nb       = nb;
    job.last     = din.in_last;
    job.total    = count_next;
    job.halted   = halted_next;
    push         = acc && ((nb != 2'd0) || din.in_last);

    if (acc && din.in_last) begin
      pos_next      = 2'd0;
      sext_next     = '0;
      third_ok_next = 1'b0;
      pb_next       = 2'b00;
      halted_next   = 1'b0;
      count_next    = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 2'd0;
      sext     <= '0;
      third_ok <= 1'b0;
      pb       <= 2'b00;
      halted   <= 1'b0;
      count    <= 32'd0;
    end else if (acc) begin
      pos      <= pos_next;
      sext     <= sext_next;
      third_ok <= third_ok_next;
      pb       <= pb_next;
      halted   <= halted_next;
      count    <= count_next;
    end
  end

endmodule

[design/b64d_queue.sv]
module b64d_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::job_t wdata,
  input  logic           pop,
  output b64d_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  b64d_pkg::job_t            mem [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QAW-1:0]  wptr, rptr;
  logic [b64d_pkg::QAW:0]    cnt;

  assign full  = (cnt == (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
      cnt <= (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH))
    else $error("queue count out of range");
  a_cnt_grow: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue count did not grow on push");
`endif

endmodule

[design/b64d_back.sv]
module b64d_back (
  input  logic           clk,
  input  logic           rst,
  input  b64d_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  b64d_out_if.source     dout
);

  logic [1:0]  idx;
  logic [2:0]  n;
  logic        step, is_last, is_byte;
  logic [7:0]  sel;

  logic        ov;
  logic [7:0]  ob;
  logic        obv, oend, ohalt, orl;
  logic [31:0] ocnt;

  assign n       = {1'b0, head.nb} + {2'b00, head.last};
  assign step    = !empty && (!ov || dout.ready);
  assign is_last = ({1'b0, idx} == (n - 3'd1));
  assign is_byte = (idx < head.nb);
  assign pop     = step && is_last;

  always_comb begin
    case (idx)
      2'd0:    sel = head.bytes[0];
      2'd1:    sel = head.bytes[1];
      2'd2:    sel = head.bytes[2];
      default: sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
      ov  <= 1'b0;
    end else begin
      if (step) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
        ov  <= 1'b1;
      end else if (dout.ready) begin
        ov  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ob    <= is_byte ? sel : 8'd0;
      obv   <= is_byte;
      oend  <= !is_byte;
      ocnt  <= is_byte ? 32'd0 : head.total;
      ohalt <= head.halted;
      orl   <= is_last;
    end
  end

  assign dout.valid       = ov;
  assign dout.out_byte    = ob;
  assign dout.byte_valid  = obv;
  assign dout.stream_end  = oend;
  assign dout.total_count = ocnt;
  assign dout.halted_flag = ohalt;
  assign dout.run_last    = orl;

endmodule
